// File: src/rwp_pkg.sv
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types and constants of the replication window planner.
// ----------------------------------------------------------------------------
package rwp_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

    localparam logic [31:0] PERIOD_RESET = 32'd86400;
    localparam logic [31:0] STEP_RESET   = 32'd3600;

    typedef enum logic [3:0] {
        OUTCOME_OK            = 4'd0,
        OUTCOME_DISABLED      = 4'd1,
        OUTCOME_NO_DIMS       = 4'd2,
        OUTCOME_CHILD_EMPTY   = 4'd3,
        OUTCOME_NEGATIVE      = 4'd4,
        OUTCOME_FIRST_GT_CLK  = 4'd5,
        OUTCOME_FIRST_GT_LAST = 4'd6,
        OUTCOME_LOCAL_AHEAD   = 4'd7,
        OUTCOME_AFTER_GT_BEF  = 4'd8
    } rwp_outcome_t;

    typedef struct packed {
        logic        enabled;
        logic [31:0] period;
        logic [31:0] step;
    } rwp_cfg_t;

    typedef struct packed {
        logic signed [63:0] child_first_time;
        logic signed [63:0] child_last_time;
        logic signed [63:0] child_clock;
        logic signed [63:0] previous_after;
        logic signed [63:0] previous_before;
        logic signed [63:0] local_last_time;
        logic signed [63:0] local_clock;
        logic               no_dimensions;
    } rwp_query_t;

    typedef struct packed {
        logic signed [63:0] wanted_after;
        logic signed [63:0] wanted_before;
        logic               stream_now;
        rwp_outcome_t       outcome;
        logic               last_was_clamped;
        logic signed [63:0] earliest_requested;
    } rwp_result_t;

endpackage

// File: src/rwp_query_if.sv
// ----------------------------------------------------------------------------
// rwp_query_if
// Valid/ready channel that carries one replication query per transfer.
// ----------------------------------------------------------------------------
interface rwp_query_if;

    logic                valid;
    logic                ready;
    rwp_pkg::rwp_query_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: src/rwp_result_if.sv
// ----------------------------------------------------------------------------
// rwp_result_if
// Valid/ready channel that carries one planned window per transfer.
// ----------------------------------------------------------------------------
interface rwp_result_if;

    logic                 valid;
    logic                 ready;
    rwp_pkg::rwp_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: src/rwp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rwp_cfg_regs
// Configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module rwp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rwp_pkg::rwp_cfg_t                cfg
);

    rwp_pkg::rwp_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled <= 1'b1;
            cfg_reg.period  <= rwp_pkg::PERIOD_RESET;
            cfg_reg.step    <= rwp_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwp_pkg::CFG_ENABLED: cfg_reg.enabled <= cfg_wdata[0];
                rwp_pkg::CFG_PERIOD:  cfg_reg.period  <= cfg_wdata;
                rwp_pkg::CFG_STEP:    cfg_reg.step    <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rwp_window_calc.sv
// ----------------------------------------------------------------------------
// rwp_window_calc
// Clamp, gap, validity checks, window and earliest-start update for a query.
// ----------------------------------------------------------------------------
module rwp_window_calc (
    input  rwp_pkg::rwp_query_t  query,
    input  rwp_pkg::rwp_cfg_t    cfg,
    input  logic signed [63:0]   earliest,
    output rwp_pkg::rwp_result_t result
);

    logic signed [63:0]   period_s;
    logic signed [63:0]   step_s;
    logic                 clamped;
    logic signed [63:0]   c_last;
    logic signed [63:0]   gap_from;
    logic signed [63:0]   win_after;
    logic signed [63:0]   span;
    logic signed [63:0]   before_step;
    logic signed [63:0]   win_before;
    logic                 stream_ok;
    logic signed [63:0]   after_out;
    logic signed [63:0]   before_out;
    logic                 stream_out;
    rwp_pkg::rwp_outcome_t code;

    assign period_s = $signed({32'd0, cfg.period});
    assign step_s   = $signed({32'd0, cfg.step});

    assign clamped = query.child_last_time > query.child_clock;
    assign c_last  = clamped ? query.child_clock : query.child_last_time;

    always_comb
    begin
        if (query.previous_after == 64'sd0 || query.previous_before == 64'sd0)
        begin
            if (query.local_last_time != 64'sd0)
            begin
                gap_from = query.local_last_time;
            end
            else
            begin
                gap_from = query.local_clock - period_s;
            end
        end
        else
        begin
            gap_from = query.previous_before;
        end
    end

    assign win_after   = (query.child_first_time > gap_from) ? query.child_first_time
                                                              : gap_from;
    assign span        = query.local_clock - win_after;
    assign before_step = (span > step_s) ? (win_after + step_s) : query.local_clock;
    assign win_before  = (before_step > c_last) ? c_last : before_step;
    assign stream_ok   = (span <= step_s) || (win_before >= c_last)
                         || (win_before >= query.child_clock)
                         || (win_before >= query.local_clock);

    always_comb
    begin
        after_out  = 64'sd0;
        before_out = 64'sd0;
        stream_out = 1'b1;
        code       = rwp_pkg::OUTCOME_OK;
        if (!cfg.enabled)
        begin
            code = rwp_pkg::OUTCOME_DISABLED;
        end
        else if (query.no_dimensions)
        begin
            code = rwp_pkg::OUTCOME_NO_DIMS;
        end
        else if (query.child_first_time == 64'sd0 || c_last == 64'sd0)
        begin
            code = rwp_pkg::OUTCOME_CHILD_EMPTY;
        end
        else if (query.child_first_time < 64'sd0 || c_last < 64'sd0)
        begin
            code = rwp_pkg::OUTCOME_NEGATIVE;
        end
        else if (query.child_first_time > query.child_clock)
        begin
            code = rwp_pkg::OUTCOME_FIRST_GT_CLK;
        end
        else if (query.child_first_time > c_last)
        begin
            code = rwp_pkg::OUTCOME_FIRST_GT_LAST;
        end
        else if (query.local_last_time > c_last)
        begin
            code = rwp_pkg::OUTCOME_LOCAL_AHEAD;
        end
        else if (win_after > win_before)
        begin
            code = rwp_pkg::OUTCOME_AFTER_GT_BEF;
        end
        else
        begin
            after_out  = win_after;
            before_out = win_before;
            stream_out = stream_ok;
        end
    end

    always_comb
    begin
        result.wanted_after     = after_out;
        result.wanted_before    = before_out;
        result.stream_now       = stream_out;
        result.outcome          = code;
        result.last_was_clamped = clamped;
        if (earliest == 64'sd0 || after_out < earliest)
        begin
            result.earliest_requested = after_out;
        end
        else
        begin
            result.earliest_requested = earliest;
        end
    end

endmodule

// File: src/replication_window_planner.sv
// ----------------------------------------------------------------------------
// replication_window_planner
// Plans the next replication request window for each incoming query.
// ----------------------------------------------------------------------------
// The planner takes one query per clock cycle while its results are taken: the
// query is captured in an input register, the window and checks are formed in
// one pass of logic, and the result waits in an output register until it is
// taken. The earliest-start register, which is updated as each result is
// formed, is the only state carried from query to query, so back-pressure on
// the result side stalls the input only when both registers are full.
// Configuration takes effect for results formed after the write, including
// that of a query already held in the input register.
module replication_window_planner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rwp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    rwp_query_if.sink                       query,
    rwp_result_if.source                    result
);

    rwp_pkg::rwp_cfg_t    cfg;
    rwp_pkg::rwp_query_t  query_reg;
    logic                 query_valid_reg;
    rwp_pkg::rwp_result_t result_reg;
    logic                 result_valid_reg;
    logic signed [63:0]   earliest_reg;
    rwp_pkg::rwp_result_t result_next;
    logic                 advance;
    logic                 query_xfer;

    rwp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rwp_window_calc u_calc (
        .query    (query_reg),
        .cfg      (cfg),
        .earliest (earliest_reg),
        .result   (result_next)
    );

    assign advance     = query_valid_reg && (!result_valid_reg || result.ready);
    assign query.ready = !query_valid_reg || advance;
    assign query_xfer  = query.valid && query.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            earliest_reg     <= 64'sd0;
        end
        else
        begin
            if (query.ready)
            begin
                query_valid_reg <= query.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                earliest_reg     <= result_next.earliest_requested;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            query_reg <= query.payload;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    // A rejected query always carries the empty window with streaming set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.outcome != rwp_pkg::OUTCOME_OK)
        |-> (result_reg.wanted_after == 64'sd0 && result_reg.wanted_before == 64'sd0
             && result_reg.stream_now))
        else $error("rejected query produced a non-empty window");

    // An accepted window is never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.outcome == rwp_pkg::OUTCOME_OK)
        |-> (result_reg.wanted_after <= result_reg.wanted_before))
        else $error("accepted window is inverted");

    // The earliest start moves only when a result is formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(earliest_reg))
        else $error("earliest start changed without a result");

    // A held query stays in the input register until it moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (query_valid_reg && !advance) |=> (query_valid_reg && $stable(query_reg)))
        else $error("stalled query was lost or changed");

    // The reported earliest start matches the register it was written to.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.earliest_requested == earliest_reg))
        else $error("reported earliest start disagrees with stored value");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the replication window planner. Queries are
// sent through the query channel with random gaps while the result channel
// is stalled at random. Every accepted query is planned by a local model of
// the planner, and each result transfer is compared field by field with the
// oldest planned window. Directed queries cover every outcome and the edges
// of the time range, then random queries run under several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic signed [63:0] T0       = 64'sd1700000000;
    localparam logic signed [63:0] MAX_TIME = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN_TIME = 64'sh8000_0000_0000_0000;
    localparam logic [31:0]        REG_MAX  = 32'hFFFF_FFFF;
    localparam int unsigned        QUIET_LIMIT  = 2000;
    localparam int unsigned        DRAIN_CYCLES = 4;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rwp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rwp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rwp_query_if  query_ch ();
    rwp_result_if result_ch ();

    replication_window_planner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .query     (query_ch),
        .result    (result_ch)
    );

    logic               plan_enabled  = 1'b1;
    logic [31:0]        plan_period   = rwp_pkg::PERIOD_RESET;
    logic [31:0]        plan_step     = rwp_pkg::STEP_RESET;
    logic signed [63:0] plan_earliest = '0;

    rwp_pkg::rwp_result_t expected_windows[$];
    bit          idle_on = 1'b1;
    int unsigned failures;
    int unsigned queries_seen;
    int unsigned results_seen;
    int unsigned clamps_seen;
    int unsigned settings_used = 1;
    int unsigned outcome_tally[16];
    int unsigned quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rwp_pkg::rwp_result_t plan_window(input rwp_pkg::rwp_query_t q);
        logic signed [63:0]    c_first;
        logic signed [63:0]    c_last;
        logic signed [63:0]    c_clock;
        logic signed [63:0]    l_last;
        logic signed [63:0]    l_clock;
        logic signed [63:0]    step_len;
        logic signed [63:0]    period_len;
        logic signed [63:0]    gap_from;
        logic signed [63:0]    gap_to;
        logic signed [63:0]    after;
        logic signed [63:0]    win_end;
        logic signed [63:0]    span;
        logic                  clamped;
        logic                  stream;
        rwp_pkg::rwp_outcome_t code;
        rwp_pkg::rwp_result_t  r;
        c_first    = q.child_first_time;
        c_last     = q.child_last_time;
        c_clock    = q.child_clock;
        l_last     = q.local_last_time;
        l_clock    = q.local_clock;
        step_len   = {32'd0, plan_step};
        period_len = {32'd0, plan_period};
        clamped    = 1'b0;
        stream     = 1'b1;
        after      = '0;
        win_end    = '0;
        code       = rwp_pkg::OUTCOME_OK;
        if (c_last > c_clock)
        begin
            c_last  = c_clock;
            clamped = 1'b1;
        end
        if (q.previous_after == 0 || q.previous_before == 0)
            gap_from = (l_last != 0) ? l_last : l_clock - period_len;
        else
            gap_from = q.previous_before;
        gap_to = l_clock;
        if (!plan_enabled)
            code = rwp_pkg::OUTCOME_DISABLED;
        else if (q.no_dimensions)
            code = rwp_pkg::OUTCOME_NO_DIMS;
        else if (c_first == 0 || c_last == 0)
            code = rwp_pkg::OUTCOME_CHILD_EMPTY;
        else if (c_first < 0 || c_last < 0)
            code = rwp_pkg::OUTCOME_NEGATIVE;
        else if (c_first > c_clock)
            code = rwp_pkg::OUTCOME_FIRST_GT_CLK;
        else if (c_first > c_last)
            code = rwp_pkg::OUTCOME_FIRST_GT_LAST;
        else if (l_last > c_last)
            code = rwp_pkg::OUTCOME_LOCAL_AHEAD;
        else
        begin
            after = (c_first > gap_from) ? c_first : gap_from;
            span  = gap_to - after;
            win_end = (span > step_len) ? after + step_len : gap_to;
            if (win_end > c_last)
                win_end = c_last;
            if (after > win_end)
            begin
                after   = '0;
                win_end = '0;
                code    = rwp_pkg::OUTCOME_AFTER_GT_BEF;
            end
            else
            begin
                span   = l_clock - after;
                stream = span <= step_len || win_end >= c_last ||
                         win_end >= c_clock || win_end >= l_clock;
            end
        end
        if (plan_earliest == 0 || after < plan_earliest)
            plan_earliest = after;
        r.wanted_after       = after;
        r.wanted_before      = win_end;
        r.stream_now         = stream;
        r.outcome            = code;
        r.last_was_clamped   = clamped;
        r.earliest_requested = plan_earliest;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (query_ch.valid && query_ch.ready)
            begin
                expected_windows.push_back(plan_window(query_ch.payload));
                queries_seen++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_windows.size() == 0)
                begin
                    $display("%0t: result transfer with no query outstanding, actual %0h",
                             $time, result_ch.payload);
                    failures++;
                end
                else
                begin
                    rwp_pkg::rwp_result_t want;
                    want = expected_windows.pop_front();
                    results_seen++;
                    outcome_tally[want.outcome]++;
                    if (want.last_was_clamped)
                        clamps_seen++;
                    check_field("wanted_after", want.wanted_after,
                                result_ch.payload.wanted_after);
                    check_field("wanted_before", want.wanted_before,
                                result_ch.payload.wanted_before);
                    check_field("stream_now", want.stream_now,
                                result_ch.payload.stream_now);
                    check_field("outcome", want.outcome, result_ch.payload.outcome);
                    check_field("last_was_clamped", want.last_was_clamped,
                                result_ch.payload.last_was_clamped);
                    check_field("earliest_requested", want.earliest_requested,
                                result_ch.payload.earliest_requested);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_ch.ready <= !(idle_on && $urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready) ||
            cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("replication_window_planner regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic rwp_pkg::rwp_query_t make_query(
        input logic signed [63:0] c_first, input logic signed [63:0] c_last,
        input logic signed [63:0] c_clock, input logic signed [63:0] p_after,
        input logic signed [63:0] p_before, input logic signed [63:0] l_last,
        input logic signed [63:0] l_clock, input int no_dims);
        rwp_pkg::rwp_query_t q;
        q.child_first_time = c_first;
        q.child_last_time  = c_last;
        q.child_clock      = c_clock;
        q.previous_after   = p_after;
        q.previous_before  = p_before;
        q.local_last_time  = l_last;
        q.local_clock      = l_clock;
        q.no_dimensions    = (no_dims != 0);
        return q;
    endfunction

    // A consistent child and local history, so that most of these pass
    // every check and reach the window arithmetic.
    function automatic rwp_pkg::rwp_query_t make_wellformed();
        rwp_pkg::rwp_query_t q;
        logic signed [63:0]  base;
        logic signed [63:0]  held_last;
        int unsigned         span;
        case ($urandom_range(3))
            0: base = 64'sd1 + $urandom_range(1000);
            1, 2: base = 64'sd1600000000 + $urandom;
            default: base = MAX_TIME - 64'sd300000 + $urandom_range(100000);
        endcase
        span = $urandom_range(50000);
        q.no_dimensions    = 1'b0;
        q.child_first_time = base;
        q.child_last_time  = base + span;
        if ($urandom_range(7) == 0)
            q.child_clock = q.child_last_time - $urandom_range(1, 100);
        else
            q.child_clock = q.child_last_time + $urandom_range(100);
        held_last = (q.child_last_time > q.child_clock) ? q.child_clock : q.child_last_time;
        case ($urandom_range(3))
            0: q.local_last_time = '0;
            1: q.local_last_time = base + $urandom_range(span);
            2: q.local_last_time = base - $urandom_range(1, 20000);
            default: q.local_last_time = held_last;
        endcase
        if ($urandom_range(9) == 0)
            q.local_clock = base - $urandom_range(1, 5000);
        else
            q.local_clock = q.child_clock + $urandom_range(8000) - 64'sd4000;
        case ($urandom_range(3))
            0:
            begin
                q.previous_after  = '0;
                q.previous_before = '0;
            end
            1:
            begin
                q.previous_after  = '0;
                q.previous_before = held_last - $urandom_range(20000);
            end
            2:
            begin
                q.previous_after  = base + $urandom_range(span);
                q.previous_before = q.previous_after + $urandom_range(20000);
            end
            default:
            begin
                q.previous_after  = held_last - $urandom_range(20000);
                q.previous_before = '0;
            end
        endcase
        return q;
    endfunction

    function automatic rwp_pkg::rwp_query_t make_broken();
        rwp_pkg::rwp_query_t q;
        q = make_wellformed();
        case ($urandom_range(7))
            0: q.no_dimensions = 1'b1;
            1: q.child_first_time = '0;
            2: q.child_last_time = '0;
            3: q.child_first_time = 64'sd0 - $urandom_range(1, 1000000);
            4: q.child_last_time = 64'sd0 - $urandom_range(1, 1000000);
            5: q.child_first_time = q.child_clock + $urandom_range(1, 1000);
            6: q.child_first_time = q.child_last_time + $urandom_range(1, 1000);
            default: q.local_last_time = q.child_last_time + $urandom_range(1, 1000);
        endcase
        return q;
    endfunction

    function automatic logic [63:0] noise_time();
        case ($urandom_range(7))
            0: return '0;
            1: return 64'sd0 - $urandom_range(1, 1000);
            2: return {32'd0, $urandom};
            default: return rand64();
        endcase
    endfunction

    function automatic rwp_pkg::rwp_query_t make_noise();
        return make_query(noise_time(), noise_time(), noise_time(), noise_time(),
                          noise_time(), noise_time(), noise_time(), $urandom_range(1));
    endfunction

    task automatic send_query(input rwp_pkg::rwp_query_t q);
        while (idle_on && $urandom_range(99) < 9)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid   <= 1'b1;
        query_ch.payload <= q;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        query_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rwp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic enabled, input logic [31:0] period,
                                  input logic [31:0] step_len);
        wait_idle();
        write_reg(rwp_pkg::CFG_ENABLED, {31'd0, enabled});
        write_reg(rwp_pkg::CFG_PERIOD, period);
        write_reg(rwp_pkg::CFG_STEP, step_len);
        plan_enabled = enabled;
        plan_period  = period;
        plan_step    = step_len;
        settings_used++;
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_query(make_wellformed());
            else if (pick < 85)
                send_query(make_broken());
            else
                send_query(make_noise());
        end
    endtask

    task automatic test_outcome_codes();
        send_query(make_query(T0 - 100000, T0, T0 + 5, 0, 0, T0 - 50000, T0 + 5, 0));
        send_query(make_query(T0 - 100000, T0, T0 + 5, T0 - 20000, T0 - 2000, T0 - 2500,
                              T0 + 5, 0));
        send_query(make_query(T0 - 100000, T0, T0, 0, 0, 0, T0, 0));
        send_query(make_query(T0 - 100000, T0 + 1000, T0, 0, 0, T0 - 10, T0, 0));
        send_query(make_query(T0 - 100000, T0, T0, 0, 0, 0, T0, 1));
        send_query(make_query(0, T0, T0, 0, 0, 0, T0, 0));
        send_query(make_query(T0, 0, T0, 0, 0, 0, T0, 0));
        send_query(make_query(MIN_TIME, T0, T0, 0, 0, 0, T0, 0));
        send_query(make_query(T0 - 10, -1, T0, 0, 0, 0, T0, 0));
        send_query(make_query(T0 + 10, T0 + 20, T0, 0, 0, 0, T0, 0));
        send_query(make_query(T0, T0 - 10, T0 + 10, 0, 0, 0, T0, 0));
        send_query(make_query(T0 - 100, T0, T0, 0, 0, T0 + 1, T0, 0));
        send_query(make_query(T0 - 100, T0, T0, T0, T0 + 100, T0 - 5, T0, 0));
        send_query(make_query(MAX_TIME, MAX_TIME, MAX_TIME, MAX_TIME, MAX_TIME, MAX_TIME,
                              MAX_TIME, 0));
        send_query(make_query(MIN_TIME, MIN_TIME, MIN_TIME, MIN_TIME, MIN_TIME, MIN_TIME,
                              MIN_TIME, 1));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, 0));
        send_query(make_query(1, T0, T0, 0, 0, 0, MIN_TIME + 5, 0));
        send_query(make_query(T0 - 7200, T0, T0 + 30, 0, 0, T0, T0 + 30, 0));
    endtask

    task automatic test_register_extremes();
        apply_settings(1'b0, rwp_pkg::PERIOD_RESET, rwp_pkg::STEP_RESET);
        send_query(make_query(T0 - 100, T0 + 50, T0, 0, 0, 0, T0, 0));
        apply_settings(1'b1, 32'd0, 32'd0);
        send_query(make_query(T0 - 10, T0, T0, 0, 0, 0, T0 - 5, 0));
        send_query(make_query(T0 - 10, T0, T0, T0 - 8, T0 - 6, T0 - 7, T0 + 5, 0));
        apply_settings(1'b1, REG_MAX, REG_MAX);
        send_query(make_query(1, MAX_TIME - 10, MAX_TIME, 0, 0, 0, MAX_TIME - 20, 0));
        send_query(make_query(1, MAX_TIME - 5, MAX_TIME, 5, MAX_TIME - 100, 0,
                              MIN_TIME + 10, 0));
        send_query(make_query(1, MAX_TIME - 5, MAX_TIME, 5, MAX_TIME - 100, 0,
                              MIN_TIME + 64'sh2_0000_0000, 0));
    endtask

    task automatic test_random_windows();
        apply_settings(1'b1, rwp_pkg::PERIOD_RESET, rwp_pkg::STEP_RESET);
        random_phase(320);
        apply_settings(1'b1, 32'd0, 32'd0);
        random_phase(160);
        apply_settings(1'b1, REG_MAX, REG_MAX);
        random_phase(160);
        apply_settings(1'b0, $urandom, $urandom);
        random_phase(120);
        apply_settings(1'b1, $urandom_range(100000), $urandom_range(60000));
        random_phase(320);
        apply_settings(1'b1, $urandom, $urandom);
        random_phase(200);
    endtask

    task automatic test_full_throughput();
        apply_settings(1'b1, 32'd7200, 32'd600);
        idle_on = 1'b0;
        random_phase(350);
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        query_ch.valid   <= 1'b0;
        query_ch.payload <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outcome_codes();
        test_register_extremes();
        test_random_windows();
        test_full_throughput();
        wait_idle();

        $display("Checked %0d results from %0d queries under %0d register settings.",
                 results_seen, queries_seen, settings_used);
        $display("Windows granted %0d, empty requests %0d, clamped child times %0d.",
                 outcome_tally[rwp_pkg::OUTCOME_OK],
                 results_seen - outcome_tally[rwp_pkg::OUTCOME_OK], clamps_seen);
        if (failures == 0)
            $display("replication_window_planner regression: pass");
        else
            $display("replication_window_planner regression: fail");
        $finish;
    end

endmodule

// File: files.f
src/rwp_pkg.sv
src/rwp_query_if.sv
src/rwp_result_if.sv
src/rwp_cfg_regs.sv
src/rwp_window_calc.sv
src/replication_window_planner.sv
sim/tb_top.sv
